// ===== src/dsv_pkg.sv =====
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types and constants of the YYYY/MM/DD date string checker.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned FIELD_W  = 7;

    localparam logic [POS_W-1:0]   DATE_LEN       = 4'd10;
    localparam logic [POS_W-1:0]   POS_SEP_YEAR   = 4'd4;
    localparam logic [POS_W-1:0]   POS_SEP_MONTH  = 4'd7;
    localparam logic [POS_W-1:0]   POS_CENT_LAST  = 4'd1;
    localparam logic [POS_W-1:0]   POS_YEAR_LAST  = 4'd3;
    localparam logic [POS_W-1:0]   POS_MONTH_LAST = 4'd6;

    localparam logic [CHAR_W-1:0]  SEP_CHAR       = 8'h2F;
    localparam logic [CHAR_W-1:0]  DIGIT_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  DIGIT_NINE     = 8'h39;

    localparam logic [YEAR_W-1:0]  MIN_YEAR_RESET = 14'd1850;

    localparam logic [FIELD_W-1:0] MONTH_FEB      = 7'd2;
    localparam logic [FIELD_W-1:0] MONTH_APR      = 7'd4;
    localparam logic [FIELD_W-1:0] MONTH_JUN      = 7'd6;
    localparam logic [FIELD_W-1:0] MONTH_SEP      = 7'd9;
    localparam logic [FIELD_W-1:0] MONTH_NOV      = 7'd11;
    localparam logic [FIELD_W-1:0] MONTH_MAX      = 7'd12;

    localparam logic [FIELD_W-1:0] DAYS_LONG      = 7'd31;
    localparam logic [FIELD_W-1:0] DAYS_SHORT     = 7'd30;
    localparam logic [FIELD_W-1:0] DAYS_FEB_LEAP  = 7'd29;
    localparam logic [FIELD_W-1:0] DAYS_FEB       = 7'd28;

    // Year kept whole for the minimum compare, and as its two digit pairs
    // for the leap-year rule.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] cent;
        logic [FIELD_W-1:0] yrlo;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [POS_W-1:0]   pos;
        logic               err;
    } t_date;

endpackage

// ===== src/date_string_validator.sv =====
// ----------------------------------------------------------------------------
// date_string_validator
// Checks a YYYY/MM/DD date string arriving one character per beat.
// ----------------------------------------------------------------------------
// Slave channel: one character per beat in i_s_tdata, i_s_tlast on the final
// character of the string. Master channel: one beat per string, bit 0 of
// o_m_tdata is 1 when the string is a valid date later than the configured
// minimum year. Config channel: i_cfg_data holds the exclusive minimum year;
// o_cfg_ready is always high, write only while no string is in flight.
// Throughput: one character per cycle, save the stall below. Each beat passes an input
// register, then the position/field update and the verdict logic, then the
// result register: the verdict is registered there as the final character
// leaves the input register.
// A stalled master holds the result register; the input register keeps
// taking characters that do not end a string, and a final character waits
// there, with o_s_tready low, until the result register is free.
// Reset: minimum year returns to 1850, position and fields clear, both
// registers empty. After each verdict the field state clears for the next
// string; the minimum year is kept.
// ----------------------------------------------------------------------------
module date_string_validator
    import dsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] char_code
    input  logic              i_s_tlast,   // is_last
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [0] date_valid, [7:1] zero
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [YEAR_W-1:0] i_cfg_data   // [13:0] min_year_exclusive
);

    logic [YEAR_W-1:0] r_min_year;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;
    t_date             r_date;
    t_date             n_date;
    logic              r_out_valid;
    logic              r_out_data;

    logic              out_free;
    logic              advance;
    logic              is_digit;
    logic [3:0]        digit;
    logic              verdict;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign advance     = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready  = !r_in_valid || advance;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {7'd0, r_out_data};

    always_comb begin
        is_digit = (r_in_char >= DIGIT_ZERO) && (r_in_char <= DIGIT_NINE);
        digit    = is_digit ? 4'(r_in_char - DIGIT_ZERO) : 4'd0;
        n_date   = r_date;
        if (r_date.pos >= DATE_LEN) begin
            n_date.err = 1'b1;
        end else begin
            if ((r_date.pos == POS_SEP_YEAR) || (r_date.pos == POS_SEP_MONTH)) begin
                if (r_in_char != SEP_CHAR) begin
                    n_date.err = 1'b1;
                end
            end else if (!is_digit) begin
                n_date.err = 1'b1;
            end else if (r_date.pos <= POS_YEAR_LAST) begin
                n_date.year = YEAR_W'(r_date.year * YEAR_W'(10) + YEAR_W'(digit));
                if (r_date.pos <= POS_CENT_LAST) begin
                    n_date.cent = FIELD_W'(r_date.cent * FIELD_W'(10) + FIELD_W'(digit));
                end else begin
                    n_date.yrlo = FIELD_W'(r_date.yrlo * FIELD_W'(10) + FIELD_W'(digit));
                end
            end else if (r_date.pos <= POS_MONTH_LAST) begin
                n_date.month = FIELD_W'(r_date.month * FIELD_W'(10) + FIELD_W'(digit));
            end else begin
                n_date.day = FIELD_W'(r_date.day * FIELD_W'(10) + FIELD_W'(digit));
            end
            n_date.pos = r_date.pos + 4'd1;
        end
    end

    dsv_check u_check (
        .i_date     (n_date),
        .i_min_year (r_min_year),
        .o_valid    (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RESET;
        end else if (i_cfg_valid) begin
            r_min_year <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_date <= '0;
            end else begin
                r_date <= n_date;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && r_in_last) begin
            r_out_data <= verdict;
        end
    end

endmodule

// ===== src/dsv_check.sv =====
// ----------------------------------------------------------------------------
// dsv_check
// Final verdict on a collected date: length, syntax, year floor, month range
// and day range with the Gregorian leap-year rule.
// ----------------------------------------------------------------------------
module dsv_check
    import dsv_pkg::*;
(
    input  t_date             i_date,
    input  logic [YEAR_W-1:0] i_min_year,
    output logic              o_valid
);

    logic               leap;
    logic [FIELD_W-1:0] day_limit;

    always_comb begin
        leap = ((i_date.yrlo == '0) && (i_date.cent[1:0] == 2'd0)) ||
               ((i_date.yrlo != '0) && (i_date.yrlo[1:0] == 2'd0));

        if (i_date.month == MONTH_FEB) begin
            day_limit = leap ? DAYS_FEB_LEAP : DAYS_FEB;
        end else if ((i_date.month == MONTH_APR) || (i_date.month == MONTH_JUN) ||
                     (i_date.month == MONTH_SEP) || (i_date.month == MONTH_NOV)) begin
            day_limit = DAYS_SHORT;
        end else begin
            day_limit = DAYS_LONG;
        end

        o_valid = !i_date.err && (i_date.pos == DATE_LEN) &&
                  (i_date.year > i_min_year) &&
                  (i_date.month != '0) && (i_date.month <= MONTH_MAX) &&
                  (i_date.day != '0) && (i_date.day <= day_limit);
    end

endmodule

// ===== tb/tb_date_string_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_date_string_validator
// Streams YYYY/MM/DD strings, one character per beat, through the checker.
// A shadow copy of the position counter and the year, month and day fields
// predicts one verdict per marked final character. Each verdict beat is
// compared in order with that prediction. The minimum year is rewritten
// between idle phases, from its extremes to values in between. Both channels
// take random gaps, and one phase holds the result side off for a long
// stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_date_string_validator;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_CHARS = 195;

    class date_verdict_tracker;
        logic [13:0] min_year;
        logic [3:0]  pos;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        bit          bad_syntax;
        bit          expected_verdicts[$];
        int unsigned mismatch_count;

        function new();
            min_year = 14'd1850;
            mismatch_count = 0;
            clear_fields();
        endfunction

        function void clear_fields();
            pos = '0;
            year = '0;
            month = '0;
            day = '0;
            bad_syntax = 1'b0;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void note_char(logic [7:0] c, bit last);
            bit          digit;
            logic [3:0]  d;
            bit          leap;
            int unsigned max_day;
            bit          ok;
            digit = (c >= 8'h30) && (c <= 8'h39);
            d = c[3:0];
            if (pos >= 4'd10) begin
                bad_syntax = 1'b1;
            end else begin
                if (pos == 4'd4 || pos == 4'd7) begin
                    if (c != 8'h2F) bad_syntax = 1'b1;
                end else if (!digit) begin
                    bad_syntax = 1'b1;
                end else if (pos <= 4'd3) begin
                    year = 14'(year * 10 + d);
                end else if (pos <= 4'd6) begin
                    month = 7'(month * 10 + d);
                end else begin
                    day = 7'(day * 10 + d);
                end
                pos = pos + 4'd1;
            end
            if (!last) return;
            leap = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
            if (month == 7'd2)
                max_day = leap ? 29 : 28;
            else if (month == 7'd4 || month == 7'd6 || month == 7'd9 || month == 7'd11)
                max_day = 30;
            else
                max_day = 31;
            ok = !bad_syntax && (pos == 4'd10) && (year > min_year) &&
                 (month >= 1) && (month <= 12) && (day >= 1) && (day <= max_day);
            expected_verdicts.push_back(ok);
            clear_fields();
        endfunction

        function void check_verdict(logic [7:0] got);
            bit want;
            if (expected_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] verdict beat with no string pending: got %0d",
                             $realtime, got);
                return;
            end
            want = expected_verdicts.pop_front();
            if (got !== {7'b0, want}) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] date_valid mismatch: expected %0d, got %0d",
                             $realtime, want, got);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [7:0]                i_s_tdata = '0;
    logic                      i_s_tlast = 1'b0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [7:0]                o_m_tdata;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [dsv_pkg::YEAR_W-1:0] i_cfg_data = '0;

    date_verdict_tracker tracker = new();
    bit          hold_req = 1'b0;
    bit          no_gaps = 1'b0;
    int          idle_cycles = 0;
    int unsigned chars_sent = 0;

    date_string_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_verdict(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random ready stretches, one long hold on request
    initial begin
        int len;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) < 70);
                len = pick_gap();
                repeat (len + 1) @(posedge i_clk);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input bit last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_string(input logic [7:0] chars[$]);
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] chars[$];
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
        send_string(chars);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min_year(input logic [13:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.min_year = value;
    endtask

    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h2F;
            4: return 8'h3A;
            5: return 8'h2E;
            6: return 8'(8'h30 + $urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_string(ref logic [7:0] chars[$]);
        int    y, m, d, n;
        string s;
        chars.delete();
        if ($urandom_range(0, 99) >= 75) begin
            n = $urandom_range(1, 14);
            repeat (n) chars.push_back(odd_char());
            return;
        end
        case ($urandom_range(0, 6))
            0: y = $urandom_range(0, 9999);
            1: y = tracker.min_year;
            2: y = tracker.min_year + 1;
            3: y = tracker.min_year - 1;
            4: y = 400 * $urandom_range(0, 24);
            5: y = 100 * $urandom_range(0, 99);
            default: y = 4 * $urandom_range(0, 2499);
        endcase
        if (y < 0) y = 0;
        if (y > 9999) y = 9999;
        if ($urandom_range(0, 99) < 85)
            m = $urandom_range(1, 12);
        else
            case ($urandom_range(0, 2))
                0: m = 0;
                1: m = 13;
                default: m = $urandom_range(0, 99);
            endcase
        case ($urandom_range(0, 7))
            4: d = $urandom_range(28, 32);
            5: d = 0;
            6: d = $urandom_range(0, 99);
            7: d = $urandom_range(30, 31);
            default: d = $urandom_range(1, 31);
        endcase
        s = $sformatf("%04d/%02d/%02d", y, m, d);
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
        if ($urandom_range(0, 99) < 25)
            case ($urandom_range(0, 2))
                0: chars[$urandom_range(0, 9)] = odd_char();
                1: chars = chars[0:$urandom_range(0, 8)];
                default: repeat ($urandom_range(1, 3)) chars.push_back(odd_char());
            endcase
    endfunction

    task automatic run_random(input int unsigned n_chars);
        logic [7:0]  chars[$];
        int unsigned stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            build_string(chars);
            send_string(chars);
        end
    endtask

    initial begin
        logic [13:0] min_years[6];
        min_years = '{14'd0, 14'd9999, 14'd3000, 14'd6143, 14'd0, 14'd1850};
        min_years[4] = 14'($urandom_range(0, 9999));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("2000/02/29");
        send_text("1999/12/311");
        send_string('{8'hFF});
        send_string('{8'h00});
        run_random(PHASE_CHARS);

        foreach (min_years[p]) begin
            drain();
            write_min_year(min_years[p]);
            if (p == 2) begin
                no_gaps = 1'b1;
                hold_req = 1'b1;
            end
            run_random(PHASE_CHARS);
            no_gaps = 1'b0;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
